FILE: rtl/i2cw_pkg.sv
package i2cw_pkg;

   localparam int unsigned AddrCount = 6;

   localparam logic [2:0] PinsIdle     = 3'd7;
   localparam logic [2:0] PinsStart    = 3'd6;
   localparam logic [2:0] PinsLowDrive = 3'd4;
   localparam logic [2:0] PinsRelease  = 3'd0;
   localparam logic [2:0] PinsAckHigh  = 3'd2;
   localparam logic [2:0] PinsDataMask = 3'd5;
   localparam logic [2:0] PinsSclBit   = 3'd2;

   typedef struct packed {
      logic       load;
      logic       shift;
      logic [7:0] value;
   } i2cw_shift_cmd_type;

   function automatic logic [7:0] dev_addr(input logic [2:0] idx);
      logic [7:0] addr;
      unique case (idx)
         3'd0:    addr = 8'h48;
         3'd1:    addr = 8'h40;
         3'd2:    addr = 8'h4A;
         3'd3:    addr = 8'h42;
         3'd4:    addr = 8'h4C;
         3'd5:    addr = 8'h44;
         default: addr = 8'h00;
      endcase
      return addr;
   endfunction

endpackage

FILE: rtl/i2cw_shift.sv
module i2cw_shift
   import i2cw_pkg::*;
(
   input  logic               clock,
   input  i2cw_shift_cmd_type cmd,
   output logic               msb
);

   logic [7:0] shift_byte_ff;
   logic [7:0] shift_byte_in;

   always_comb begin
      shift_byte_in = shift_byte_ff;
      if (cmd.load) begin
         shift_byte_in = cmd.value;
      end else if (cmd.shift) begin
         shift_byte_in = {shift_byte_ff[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      shift_byte_ff <= shift_byte_in;
   end

   assign msb = shift_byte_ff[7];

endmodule

FILE: rtl/i2c_two_byte_write_sequencer_top.sv
// Channel  Dir  tdata (low bit up)                 tuser       tlast
// req      in   port_index[2:0], enable_byte[10:3]  -           -
// rsp      out  pin_word[2:0]                      bad_index   last_word
//
// One beat in gives 61 beats out (2 for an invalid port index), one per cycle
// while rsp_tready is high.
// The word sequencer emits one pin word a cycle through a single output register.
// req_tready is high only while the sequencer is idle. rsp stalls freeze it.
// Synchronous reset returns to idle with the bus pins at 7.
module i2c_two_byte_write_sequencer_top
   import i2cw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // port_index[2:0], enable_byte[10:3], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pin_word[2:0], zero pad
   output logic        rsp_tuser,   // bad_index
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_BIT,
      ST_BYTE_END,
      ST_ACK,
      ST_STOP
   } state_type;

   state_type          state_ff;
   logic [1:0]         sub_ff;
   logic [2:0]         bit_ff;
   logic               second_ff;
   logic [2:0]         index_ff;
   logic [7:0]         enable_ff;
   logic [2:0]         pins_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_pins_ff;
   logic               rsp_last_ff;
   logic               rsp_bad_ff;
   logic               msb;
   logic               advance;
   logic               bad_index;
   i2cw_shift_cmd_type shift_cmd;

   assign req_tready = (state_ff == ST_IDLE);
   assign advance    = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign bad_index  = (index_ff > 3'(AddrCount - 1));

   always_comb begin
      shift_cmd.load  = 1'b0;
      shift_cmd.shift = 1'b0;
      shift_cmd.value = dev_addr(index_ff);
      if (advance) begin
         if (state_ff == ST_START && sub_ff == 2'd1 && !bad_index) begin
            shift_cmd.load = 1'b1;
         end else if (state_ff == ST_ACK && sub_ff == 2'd2 && !second_ff) begin
            shift_cmd.load  = 1'b1;
            shift_cmd.value = enable_ff;
         end else if (state_ff == ST_BIT && sub_ff == 2'd2) begin
            shift_cmd.shift = 1'b1;
         end
      end
   end

   i2cw_shift u_shift (
      .clock (clock),
      .cmd   (shift_cmd),
      .msb   (msb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= 2'd0;
         bit_ff       <= 3'd0;
         second_ff    <= 1'b0;
         pins_ff      <= PinsIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_tvalid && req_tready) begin
            index_ff  <= req_tdata[2:0];
            enable_ff <= req_tdata[10:3];
            state_ff  <= ST_START;
            sub_ff    <= 2'd0;
            bit_ff    <= 3'd0;
            second_ff <= 1'b0;
         end else if (advance) begin
            logic [2:0] word;
            logic       last;
            logic       bad;
            word = PinsIdle;
            last = 1'b0;
            bad  = 1'b0;
            sub_ff <= sub_ff + 2'd1;
            unique case (state_ff)
               ST_START: begin
                  if (sub_ff == 2'd0) begin
                     word = PinsIdle;
                  end else begin
                     word   = PinsStart;
                     sub_ff <= 2'd0;
                     if (bad_index) begin
                        last     = 1'b1;
                        bad      = 1'b1;
                        state_ff <= ST_IDLE;
                     end else begin
                        state_ff <= ST_BIT;
                        bit_ff   <= 3'd0;
                     end
                  end
               end
               ST_BIT: begin
                  unique case (sub_ff)
                     2'd0:    word = (bit_ff == 3'd0) ? PinsLowDrive
                                                      : (pins_ff & PinsDataMask);
                     2'd1:    word = msb ? PinsDataMask : PinsLowDrive;
                     default: begin
                        word   = (msb ? PinsDataMask : PinsLowDrive) | PinsSclBit;
                        sub_ff <= 2'd0;
                        bit_ff <= bit_ff + 3'd1;
                        if (bit_ff == 3'd7) begin
                           state_ff <= ST_BYTE_END;
                        end
                     end
                  endcase
               end
               ST_BYTE_END: begin
                  word     = pins_ff & PinsDataMask;
                  sub_ff   <= 2'd0;
                  state_ff <= ST_ACK;
               end
               ST_ACK: begin
                  word = (sub_ff == 2'd1) ? PinsAckHigh : PinsRelease;
                  if (sub_ff == 2'd2) begin
                     sub_ff <= 2'd0;
                     if (second_ff) begin
                        state_ff <= ST_STOP;
                     end else begin
                        second_ff <= 1'b1;
                        bit_ff    <= 3'd0;
                        state_ff  <= ST_BIT;
                     end
                  end
               end
               ST_STOP: begin
                  unique case (sub_ff)
                     2'd0:    word = PinsLowDrive;
                     2'd1:    word = PinsStart;
                     default: begin
                        word     = PinsIdle;
                        last     = 1'b1;
                        sub_ff   <= 2'd0;
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
               default: begin
                  word = pins_ff;
               end
            endcase
            pins_ff      <= word;
            rsp_pins_ff  <= word;
            rsp_last_ff  <= last;
            rsp_bad_ff   <= bad;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_pins_ff};
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cw_pkg::*;

   localparam int RANDOM_ITEMS = 256;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 70;
   localparam int MAX_SHOWN    = 10;

   localparam logic [7:0] DEVICE_ADDR [AddrCount] = '{8'h48, 8'h40, 8'h4A, 8'h42, 8'h4C, 8'h44};

   typedef struct packed {
      logic [2:0] pins;
      logic       last;
      logic       bad;
   } pin_beat_type;

   typedef struct {
      logic [2:0] port;
      logic [7:0] data;
      bit         typed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   pin_beat_type pending_words[$];
   pin_beat_type want;
   int        fault_count = 0;
   int        words_checked = 0;
   int        items_sent = 0;
   int        aborts_sent = 0;
   int        burst_left = 1;
   int        holds_done = 0;
   bit        hold_req = 1'b0;

   stim_row_type directed_rows[14] = '{
      '{3'd0, 8'h00, 1'b0}, '{3'd0, 8'hFF, 1'b0}, '{3'd1, 8'hAA, 1'b0},
      '{3'd2, 8'h55, 1'b0}, '{3'd3, 8'h01, 1'b0}, '{3'd4, 8'h80, 1'b0},
      '{3'd5, 8'hFF, 1'b0}, '{3'd5, 8'h00, 1'b0}, '{3'd6, 8'h00, 1'b1},
      '{3'd7, 8'hFF, 1'b1}, '{3'd6, 8'hA5, 1'b1}, '{3'd7, 8'h5A, 1'b1},
      '{3'd3, 8'h7E, 1'b0}, '{3'd4, 8'h81, 1'b0}
   };

   i2c_two_byte_write_sequencer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void push_word(logic [2:0] pins, logic last, logic bad);
      pin_beat_type w;
      w.pins = pins;
      w.last = last;
      w.bad  = bad;
      pending_words.push_back(w);
   endfunction

   // three words per bit, MSB first, then one SCL-low trailer
   function automatic void push_octet(logic [7:0] value);
      logic [2:0] pins;
      logic [7:0] shreg;
      pins  = PinsLowDrive;
      shreg = value;
      for (int i = 0; i < 8; i++) begin
         push_word(pins & PinsDataMask, 1'b0, 1'b0);
         pins = shreg[7] ? (PinsLowDrive | 3'd1) : PinsLowDrive;
         push_word(pins, 1'b0, 1'b0);
         pins = pins | PinsSclBit;
         push_word(pins, 1'b0, 1'b0);
         shreg = shreg << 1;
      end
      push_word(pins & PinsDataMask, 1'b0, 1'b0);
   endfunction

   function automatic void push_ack_slot();
      push_word(PinsRelease, 1'b0, 1'b0);
      push_word(PinsAckHigh, 1'b0, 1'b0);
      push_word(PinsRelease, 1'b0, 1'b0);
   endfunction

   function automatic void predict_write(logic [2:0] port, logic [7:0] data);
      push_word(PinsIdle, 1'b0, 1'b0);
      if (port >= AddrCount) begin
         push_word(PinsStart, 1'b1, 1'b1);
         return;
      end
      push_word(PinsStart, 1'b0, 1'b0);
      push_octet(DEVICE_ADDR[port]);
      push_ack_slot();
      push_octet(data);
      push_ack_slot();
      push_word(PinsLowDrive, 1'b0, 1'b0);
      push_word(PinsStart, 1'b0, 1'b0);
      push_word(PinsIdle, 1'b1, 1'b0);
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= MAX_SHOWN)
         $display("%t mismatch: %s", $realtime, msg);
   endtask

   task automatic offer(logic [2:0] port, logic [7:0] data, bit typed);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, data, port};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (port >= AddrCount)
         aborts_sent++;
      if (typed) begin
         push_word(PinsIdle, 1'b0, 1'b0);
         push_word(PinsStart, 1'b1, 1'b1);
      end else begin
         predict_write(port, data);
      end
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
   endtask

   // receiver: runs of differing ready patterns, plus one long hold-off on request
   initial begin
      int mode;
      int run_len;
      int tick;
      mode    = 0;
      run_len = 0;
      tick    = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            if (run_len == 0) begin
               mode    = $urandom_range(0, 3);
               run_len = $urandom_range(20, 200);
            end
            run_len--;
            tick++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ((tick % 5) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            note_fault($sformatf("unexpected beat pins=%0d last=%0b bad=%0b",
                                 rsp_tdata[2:0], rsp_tlast, rsp_tuser));
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_tdata[2:0] !== want.pins || rsp_tlast !== want.last ||
                rsp_tuser !== want.bad)
               note_fault($sformatf("beat %0d pins %0d/%0d last %0b/%0b bad %0b/%0b (exp/got)",
                                    words_checked, want.pins, rsp_tdata[2:0],
                                    want.last, rsp_tlast, want.bad, rsp_tuser));
         end
      end
   end

   initial begin
      logic [2:0] port;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer(directed_rows[i].port, directed_rows[i].data, directed_rows[i].typed);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40)
            hold_req = 1'b1;
         if (i == 150) begin
            req_tvalid <= 1'b0;
            while (pending_words.size() != 0) @(posedge clock);
            @(posedge clock);
         end
         port = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 5))
                                             : 3'($urandom_range(6, 7));
         offer(port, 8'($urandom), 1'b0);
      end
      req_tvalid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d writes (%0d with a bad port index), checked %0d pin words,",
               items_sent, aborts_sent, words_checked);
      $display("with %0d long output hold-off(s) and one full drain pause.", holds_done);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatching beat(s)", fault_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("run timed out with %0d pin word(s) outstanding", pending_words.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
rtl/i2cw_pkg.sv
rtl/i2cw_shift.sv
rtl/i2c_two_byte_write_sequencer_top.sv
test/testbench.sv
